FILE: hdl/b64d_pkg.sv
`default_nettype none
package b64d_pkg;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BAD_CHAR  = 3'd1;
    localparam logic [2:0] ST_AFTER_PAD = 3'd2;
    localparam logic [2:0] ST_BAD_LEN   = 3'd3;
    localparam logic [2:0] ST_PAD_BITS  = 3'd4;

    localparam logic KIND_DATA   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    localparam logic [7:0] CH_PAD = 8'h3D;

    // one queued command: optional data word, then optional status word
    typedef struct packed {
        logic       has_byte;
        logic [7:0] data_byte;
        logic       has_status;
        logic [2:0] status;
    } b64d_entry_t;

    function automatic logic is_space(input logic [7:0] c);
        is_space = (c == 8'h20) || (c == 8'h0A) || (c == 8'h0D) ||
                   (c == 8'h09) || (c == 8'h0C) || (c == 8'h0B);
    endfunction

    // bit 6 set: not in the alphabet
    function automatic logic [6:0] sextet_of(input logic [7:0] c);
        logic [6:0] v;
        v = 7'h40;
        if (c >= 8'h41 && c <= 8'h5A) v = 7'(c - 8'h41);
        else if (c >= 8'h61 && c <= 8'h7A) v = 7'(c - 8'h61 + 8'd26);
        else if (c >= 8'h30 && c <= 8'h39) v = 7'(c - 8'h30 + 8'd52);
        else if (c == 8'h2B) v = 7'd62;
        else if (c == 8'h2F) v = 7'd63;
        sextet_of = v;
    endfunction

endpackage
`default_nettype wire

FILE: hdl/base64_stream_decoder_top.sv
// Streaming base64 decoder, one text character per input word.
// Input: s_axis_tdata[7:0] carries the character, s_axis_tlast marks the
// final character of a message. Whitespace is skipped, '=' is padding.
// Output: one word per decoded byte, plus one status word per message.
//   m_axis_tuser = 0: data word, m_axis_tdata[7:0] is the byte.
//   m_axis_tuser = 1: status word, m_axis_tdata[10:8] is the status
//   (0 ok, 1 bad char, 2 data after pad, 3 bad length, 4 nonzero pad bits).
//   m_axis_tlast marks the last output word caused by one input word.
// Throughput: one character per cycle while the queue is not full. A character
// that yields both a byte and the status needs two output words; the command
// queue absorbs this. The first output word of a character is written into the
// queue, then loaded into the output register.
// Stall: when the receiver holds m_axis_tready low the queue fills
// (QUEUE_DEPTH commands), then s_axis_tready drops.
// Reset: aresetn (synchronous) clears decoder state, queue and output valid.
`default_nettype none
module base64_stream_decoder_top
    import b64d_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] char_in
    input  wire logic        s_axis_tlast,   // end_of_text
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata,   // [7:0] data_byte, [10:8] status
    output logic             m_axis_tuser,   // kind
    output logic             m_axis_tlast    // run_last
);

    logic        q_full;
    logic        push;
    b64d_entry_t push_entry;
    logic        pop;
    logic        head_valid;
    b64d_entry_t head;

    b64d_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .char_in     (s_axis_tdata),
        .end_of_text (s_axis_tlast),
        .q_full      (q_full),
        .push        (push),
        .push_entry  (push_entry)
    );

    b64d_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head)
    );

    b64d_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .m_valid    (m_axis_tvalid),
        .m_ready    (m_axis_tready),
        .m_data     (m_axis_tdata),
        .m_kind     (m_axis_tuser),
        .m_last     (m_axis_tlast)
    );

endmodule
`default_nettype wire

FILE: hdl/b64d_front.sv
`default_nettype none
module b64d_front
    import b64d_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  char_in,
    input  wire logic        end_of_text,
    input  wire logic        q_full,
    output logic             push,
    output b64d_entry_t      push_entry
);

    logic [11:0] buf_reg, buf_next;
    logic [2:0]  bcnt_reg, bcnt_next;
    logic [1:0]  dcnt_reg, dcnt_next;
    logic        pad_reg, pad_next;
    logic [2:0]  err_reg, err_next;

    logic        accept;
    logic [6:0]  sx;
    logic [3:0]  cnt;
    logic [2:0]  sh;
    logic [11:0] shifted;
    logic [11:0] mask;
    logic [2:0]  st;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    assign sx       = sextet_of(char_in);

    always_comb begin
        buf_next   = buf_reg;
        bcnt_next  = bcnt_reg;
        dcnt_next  = dcnt_reg;
        pad_next   = pad_reg;
        err_next   = err_reg;
        cnt        = {1'b0, bcnt_reg} + 4'd6;
        sh         = 3'(cnt - 4'd8);
        shifted    = '0;
        push_entry = '0;
        if (err_reg == ST_OK && !is_space(char_in)) begin
            if (char_in == CH_PAD) begin
                pad_next = 1'b1;
            end else if (pad_reg) begin
                err_next = ST_AFTER_PAD;
            end else if (sx[6]) begin
                err_next = ST_BAD_CHAR;
            end else begin
                buf_next  = {buf_reg[5:0], sx[5:0]};
                dcnt_next = dcnt_reg + 2'd1;
                if (cnt >= 4'd8) begin
                    shifted              = buf_next >> sh;
                    push_entry.has_byte  = 1'b1;
                    push_entry.data_byte = shifted[7:0];
                    bcnt_next            = sh;
                end else begin
                    bcnt_next = cnt[2:0];
                end
            end
        end
        mask = (12'd1 << bcnt_next) - 12'd1;
        st   = err_next;
        if (st == ST_OK) begin
            if (dcnt_next == 2'd1) begin
                st = ST_BAD_LEN;
            end else if (bcnt_next != 3'd0 && (buf_next & mask) != 12'd0) begin
                st = ST_PAD_BITS;
            end
        end
        push_entry.has_status = end_of_text;
        push_entry.status     = end_of_text ? st : ST_OK;
    end

    assign push = accept && (push_entry.has_byte || push_entry.has_status);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            buf_reg  <= '0;
            bcnt_reg <= '0;
            dcnt_reg <= '0;
            pad_reg  <= 1'b0;
            err_reg  <= ST_OK;
        end else if (accept) begin
            if (end_of_text) begin
                buf_reg  <= '0;
                bcnt_reg <= '0;
                dcnt_reg <= '0;
                pad_reg  <= 1'b0;
                err_reg  <= ST_OK;
            end else begin
                buf_reg  <= buf_next;
                bcnt_reg <= bcnt_next;
                dcnt_reg <= dcnt_next;
                pad_reg  <= pad_next;
                err_reg  <= err_next;
            end
        end
    end

endmodule
`default_nettype wire

FILE: hdl/b64d_queue.sv
`default_nettype none
module b64d_queue
    import b64d_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        push,
    input  wire b64d_entry_t push_entry,
    output logic             full,
    input  wire logic        pop,
    output logic             head_valid,
    output b64d_entry_t      head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    b64d_entry_t       entries_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = entries_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            entries_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (push && !pop) begin
                count_reg <= count_reg + CNT_W'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        full |-> !push)
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !head_valid |-> !pop)
        else $error("queue pop while empty");

    a_count_up: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("queue count did not advance on push");
`endif

endmodule
`default_nettype wire

FILE: hdl/b64d_back.sv
`default_nettype none
module b64d_back
    import b64d_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        head_valid,
    input  wire b64d_entry_t head,
    output logic             pop,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [15:0]      m_data,
    output logic             m_kind,
    output logic             m_last
);

    logic        valid_reg;
    logic        byte_done_reg;
    logic [7:0]  byte_reg;
    logic [2:0]  status_reg;
    logic        kind_reg;
    logic        last_reg;
    logic        load;
    logic        emit_byte;

    assign load      = head_valid && (!valid_reg || m_ready);
    assign emit_byte = head.has_byte && !byte_done_reg;
    assign pop       = load && (!emit_byte || !head.has_status);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg     <= 1'b0;
            byte_done_reg <= 1'b0;
        end else begin
            if (load) begin
                valid_reg     <= 1'b1;
                byte_done_reg <= emit_byte && head.has_status;
            end else if (m_ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            if (emit_byte) begin
                byte_reg   <= head.data_byte;
                status_reg <= ST_OK;
                kind_reg   <= KIND_DATA;
                last_reg   <= !head.has_status;
            end else begin
                byte_reg   <= 8'h00;
                status_reg <= head.status;
                kind_reg   <= KIND_STATUS;
                last_reg   <= 1'b1;
            end
        end
    end

    assign m_valid = valid_reg;
    assign m_data  = {5'b0, status_reg, byte_reg};
    assign m_kind  = kind_reg;
    assign m_last  = last_reg;

endmodule
`default_nettype wire

FILE: tb/tb_base64_stream_decoder_top.sv
`timescale 1ns / 100ps
module tb_base64_stream_decoder_top;
    import b64d_pkg::*;

    typedef struct {
        logic [7:0] ch;
        logic       eot;
    } text_char_t;

    typedef struct {
        logic       kind;
        logic [7:0] data_byte;
        logic [2:0] status;
        logic       run_last;
    } dec_word_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        m_axis_tlast;

    text_char_t text_q[$];
    dec_word_t  decoded_q[$];
    int         total_chars = 1;
    int         chars_sent = 0;
    int         mismatches = 0;
    int         hold_left = 0;
    bit         hold_done = 0;

    // decoder state
    logic [11:0] acc_bits = '0;
    logic [2:0]  bit_cnt = '0;
    logic [1:0]  sym_cnt = '0;
    logic        pad_flag = 1'b0;
    logic [2:0]  err_code = ST_OK;

    base64_stream_decoder_top i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    function automatic logic blank_char(input logic [7:0] c);
        return c == 8'h20 || c == 8'h09 || c == 8'h0A || c == 8'h0D ||
               c == 8'h0C || c == 8'h0B;
    endfunction

    // bit 6 set: not in the alphabet
    function automatic logic [6:0] char_value(input logic [7:0] c);
        if (c >= "A" && c <= "Z") return 7'(c - "A");
        if (c >= "a" && c <= "z") return 7'(c - "a" + 26);
        if (c >= "0" && c <= "9") return 7'(c - "0" + 52);
        if (c == "+") return 7'd62;
        if (c == "/") return 7'd63;
        return 7'h40;
    endfunction

    function automatic logic [7:0] sym_char(input logic [5:0] v);
        if (v < 26) return 8'("A" + v);
        if (v < 52) return 8'("a" + v - 26);
        if (v < 62) return 8'("0" + v - 52);
        return (v == 62) ? 8'h2B : 8'h2F;
    endfunction

    function automatic logic [7:0] random_blank();
        case ($urandom_range(0, 5))
            0: return 8'h20;
            1: return 8'h09;
            2: return 8'h0A;
            3: return 8'h0D;
            4: return 8'h0C;
            default: return 8'h0B;
        endcase
    endfunction

    function automatic void decode_char(input logic [7:0] c, input logic eot);
        dec_word_t  w[2];
        int         n;
        logic [6:0] v;
        logic [3:0] cnt;
        logic [2:0] st;
        n = 0;
        if (err_code == ST_OK && !blank_char(c)) begin
            if (c == CH_PAD) begin
                pad_flag = 1'b1;
            end else if (pad_flag) begin
                err_code = ST_AFTER_PAD;
            end else begin
                v = char_value(c);
                if (v[6]) begin
                    err_code = ST_BAD_CHAR;
                end else begin
                    cnt = {1'b0, bit_cnt} + 4'd6;
                    acc_bits = {acc_bits[5:0], v[5:0]};
                    sym_cnt = sym_cnt + 2'd1;
                    if (cnt >= 4'd8) begin
                        cnt = cnt - 4'd8;
                        w[n] = '{KIND_DATA, 8'(acc_bits >> cnt), ST_OK, 1'b0};
                        n++;
                    end
                    bit_cnt = cnt[2:0];
                end
            end
        end
        if (eot) begin
            st = err_code;
            if (st == ST_OK) begin
                if (sym_cnt == 2'd1)
                    st = ST_BAD_LEN;
                else if ((acc_bits & ((12'd1 << bit_cnt) - 12'd1)) != 12'd0)
                    st = ST_PAD_BITS;
            end
            w[n] = '{KIND_STATUS, 8'h00, st, 1'b0};
            n++;
            acc_bits = '0;
            bit_cnt = '0;
            sym_cnt = '0;
            pad_flag = 1'b0;
            err_code = ST_OK;
        end
        if (n > 0)
            w[n-1].run_last = 1'b1;
        for (int i = 0; i < n; i++)
            decoded_q.insert(decoded_q.size(), w[i]);
    endfunction

    function automatic void push_char(input logic [7:0] c, input logic eot);
        text_q.insert(text_q.size(), '{c, eot});
    endfunction

    function automatic void add_text(input string s);
        for (int i = 0; i < s.len(); i++)
            push_char(s[i], i == s.len() - 1);
    endfunction

    function automatic void add_random_msg();
        logic [7:0] msg[$];
        logic [5:0] sx[$];
        int         mode;
        int         n_groups;
        int         tail;
        mode = $urandom_range(0, 11);
        if (mode == 11) begin
            repeat ($urandom_range(1, 8))
                msg.insert(msg.size(), 8'($urandom_range(0, 255)));
        end else begin
            n_groups = $urandom_range(0, (mode == 10) ? 6 : 2);
            repeat (n_groups * 4)
                sx.insert(sx.size(), 6'($urandom_range(0, 63)));
            case ($urandom_range(0, 2))
                0: tail = 0;
                1: tail = 2;
                default: tail = 3;
            endcase
            if (tail == 2) begin
                sx.insert(sx.size(), 6'($urandom_range(0, 63)));
                sx.insert(sx.size(),
                          6'($urandom_range(0, 63)) & ((mode == 7) ? 6'h3F : 6'h30));
            end else if (tail == 3) begin
                sx.insert(sx.size(), 6'($urandom_range(0, 63)));
                sx.insert(sx.size(), 6'($urandom_range(0, 63)));
                sx.insert(sx.size(),
                          6'($urandom_range(0, 63)) & ((mode == 7) ? 6'h3F : 6'h3C));
            end
            foreach (sx[i]) begin
                if ($urandom_range(0, 7) == 0)
                    msg.insert(msg.size(), random_blank());
                msg.insert(msg.size(), sym_char(sx[i]));
            end
            if (tail > 0 && $urandom_range(0, 3) != 0)
                repeat (4 - tail)
                    msg.insert(msg.size(), CH_PAD);
            if (mode == 6)
                msg.insert($urandom_range(0, msg.size()), 8'($urandom_range(0, 255)));
            else if (mode == 8 && msg.size() > 0)
                void'(msg.pop_back());
            else if (mode == 9) begin
                msg.insert(msg.size(), CH_PAD);
                msg.insert(msg.size(), sym_char(6'($urandom_range(0, 63))));
            end
            if ($urandom_range(0, 5) == 0)
                msg.insert(msg.size(), random_blank());
        end
        if (msg.size() == 0)
            msg.insert(msg.size(), random_blank());
        foreach (msg[i])
            push_char(msg[i], i == msg.size() - 1);
    endfunction

    function automatic int send_idle_pct();
        case (chars_sent * 3 / total_chars)
            0: return 38;
            1: return 45;
            default: return 0;
        endcase
    endfunction

    function automatic int recv_idle_pct();
        case (chars_sent * 3 / total_chars)
            0: return 45;
            1: return 38;
            default: return 0;
        endcase
    endfunction

    initial begin
        forever #4 aclk = ~aclk;
    end

    initial begin
        #2000000;
        $display("simulation failed");
        $finish;
    end

    initial begin
        add_text("+/9z");
        add_text("QR==");
        push_char(8'h09, 1'b0);
        push_char("Q", 1'b1);
        add_text("Q=A");
        push_char(8'h0B, 1'b1);
        push_char(8'hFF, 1'b0);
        push_char("A", 1'b0);
        push_char(8'h00, 1'b1);
        push_char(8'h20, 1'b0);
        push_char(8'h0D, 1'b0);
        push_char(8'h0A, 1'b0);
        push_char(8'h0C, 1'b1);
        add_text("TQ");
        add_text("=");
        while (text_q.size() < 1425)
            add_random_msg();
        total_chars = text_q.size();

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        while (text_q.size() > 0 || s_axis_tvalid)
            @(posedge aclk);
        while (decoded_q.size() > 0)
            @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // character driver
    always @(posedge aclk) begin
        text_char_t nxt;
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                decode_char(s_axis_tdata, s_axis_tlast);
                chars_sent++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (text_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct()) begin
                    nxt = text_q.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= nxt.ch;
                    s_axis_tlast  <= nxt.eot;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver ready, with one long hold-off so the queue fills and stalls the input
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (!hold_done && chars_sent >= total_chars / 6) begin
                hold_left = 300;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct());
            end
        end
    end

    // output word monitor
    always @(posedge aclk) begin
        dec_word_t w;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (decoded_q.size() == 0) begin
                $display("%0t: unexpected word: expected none, actual kind=%0d tdata=%h last=%0d",
                         $time, m_axis_tuser, m_axis_tdata, m_axis_tlast);
                mismatches++;
            end else begin
                w = decoded_q.pop_front();
                if (m_axis_tuser !== w.kind || m_axis_tdata[7:0] !== w.data_byte ||
                    m_axis_tdata[10:8] !== w.status || m_axis_tdata[15:11] !== 5'd0 ||
                    m_axis_tlast !== w.run_last) begin
                    $display({"%0t: mismatch: expected kind=%0d byte=%h status=%0d last=%0d,",
                              " actual kind=%0d byte=%h status=%0d last=%0d pad=%h"},
                             $time, w.kind, w.data_byte, w.status, w.run_last,
                             m_axis_tuser, m_axis_tdata[7:0], m_axis_tdata[10:8],
                             m_axis_tlast, m_axis_tdata[15:11]);
                    mismatches++;
                end
            end
        end
    end

endmodule

FILE: base64_stream_decoder_top.f
hdl/b64d_pkg.sv
hdl/b64d_front.sv
hdl/b64d_queue.sv
hdl/b64d_back.sv
hdl/base64_stream_decoder_top.sv
tb/tb_base64_stream_decoder_top.sv
